// ===== src/gaussian_normal_from_quaternion_core_defines.svh =====
// ----------------------------------------------------------------------------
// gaussian normal core assertion macros
// shared assertion shorthands for the normal pipeline
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_NORMAL_FROM_QUATERNION_CORE_DEFINES_SVH
`define GAUSSIAN_NORMAL_FROM_QUATERNION_CORE_DEFINES_SVH

// implication checked on every edge outside reset
`define GNQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define GNQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gnq_pkg.sv =====
// ----------------------------------------------------------------------------
// gnq_pkg
// types and constants of the gaussian normal pipeline
// ----------------------------------------------------------------------------
package gnq_pkg;

    localparam logic [15:0] OUT_ONE  = 16'd16384;
    localparam logic signed [35:0] Q24_ONE = 36'sd16777216;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // position of the leading one, 0 when zero
    function automatic logic [5:0] lead_one(input logic [35:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 36; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== src/gaussian_normal_from_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// gaussian_normal_from_quaternion_core
// unit normal of a 3d gaussian from a quaternion or a supplied normal
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer is accepted every cycle while the output is not
// stalled. The pipeline holds four front stages (products, matrix column, common
// shift, sum of squares), a 32-stage square root that settles one root bit per
// stage and a 16-stage restoring division per lane that settles one quotient bit
// per stage. The pipeline stalls as a whole while m_tvalid is high and m_tready
// is low; s_tready follows m_tready combinationally in that case.
module gaussian_normal_from_quaternion_core #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // given_nx, given_ny, given_nz, quat_w, quat_x, quat_y, quat_z,
    // log_scale_x, log_scale_y, log_scale_z (lowest bit first)
    input  logic [((10*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    // has_given_normal
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // unit_nx, unit_ny, unit_nz
    output logic [47:0]                  m_tdata,
    // degenerate
    output logic                         m_tuser
);
    import gnq_pkg::*;
    `include "gaussian_normal_from_quaternion_core_defines.svh"

    localparam int CW   = COMPONENT_WIDTH;
    localparam int NSQ  = 32;
    localparam int NDIV = 16;
    localparam int LAT  = 4 + NSQ + NDIV;

    // ---------------- pipeline enable ----------------
    logic en;
    logic [LAT-1:0] r_vld;
    logic s_fire;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_tvalid};
        end
    end
    assign m_tvalid = r_vld[LAT-1];

    function automatic logic signed [15:0] sat16(input logic [CW-1:0] v);
        logic signed [32:0] s;
        s = 33'($signed(v));
        if (s > 33'sd32767) begin
            return 16'sd32767;
        end else if (s < -33'sd32768) begin
            return -16'sd32768;
        end
        return 16'(s);
    endfunction

    // ---------------- stage 0: unpack, axis pick, products ----------------
    logic signed [15:0] gx, gy, gz, qr, qx, qy, qz;
    logic signed [CW-1:0] sx, sy, sz;
    t_axis ax;
    always_comb begin
        gx = sat16(s_tdata[0*CW +: CW]);
        gy = sat16(s_tdata[1*CW +: CW]);
        gz = sat16(s_tdata[2*CW +: CW]);
        qr = sat16(s_tdata[3*CW +: CW]);
        qx = sat16(s_tdata[4*CW +: CW]);
        qy = sat16(s_tdata[5*CW +: CW]);
        qz = sat16(s_tdata[6*CW +: CW]);
        sx = $signed(s_tdata[7*CW +: CW]);
        sy = $signed(s_tdata[8*CW +: CW]);
        sz = $signed(s_tdata[9*CW +: CW]);
        ax = (sy < sx) ? AXIS_Y : AXIS_X;
        if (((ax == AXIS_X) ? sx : sy) > sz) begin
            ax = AXIS_Z;
        end
    end

    // nine products of the quaternion
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_rx, r_ry, r_rz;
    logic signed [15:0] r_gx, r_gy, r_gz;
    logic r_giv0;
    t_axis r_ax0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx <= qx * qx; r_yy <= qy * qy; r_zz <= qz * qz;
            r_xy <= qx * qy; r_xz <= qx * qz; r_yz <= qy * qz;
            r_rx <= qr * qx; r_ry <= qr * qy; r_rz <= qr * qz;
            r_gx <= gx; r_gy <= gy; r_gz <= gz;
            r_giv0 <= s_tuser; r_ax0 <= ax;
        end
    end

    // ---------------- stage 1: matrix column ----------------
    logic signed [35:0] c0, c1, c2;
    always_comb begin
        if (r_giv0) begin
            c0 = 36'(r_gx); c1 = 36'(r_gy); c2 = 36'(r_gz);
        end else begin
            case (r_ax0)
                AXIS_X: begin
                    c0 = Q24_ONE - 36'(2) * (36'(r_yy) + 36'(r_zz));
                    c1 = 36'(2) * (36'(r_xy) + 36'(r_rz));
                    c2 = 36'(2) * (36'(r_xz) - 36'(r_ry));
                end
                AXIS_Y: begin
                    c0 = 36'(2) * (36'(r_xy) - 36'(r_rz));
                    c1 = Q24_ONE - 36'(2) * (36'(r_xx) + 36'(r_zz));
                    c2 = 36'(2) * (36'(r_yz) + 36'(r_rx));
                end
                default: begin
                    c0 = 36'(2) * (36'(r_xz) + 36'(r_ry));
                    c1 = 36'(2) * (36'(r_yz) - 36'(r_rx));
                    c2 = Q24_ONE - 36'(2) * (36'(r_xx) + 36'(r_yy));
                end
            endcase
        end
    end

    logic [35:0] r_m1 [3];
    logic [2:0] r_neg1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1[0] <= c0[35] ? 36'(-c0) : 36'(c0);
            r_m1[1] <= c1[35] ? 36'(-c1) : 36'(c1);
            r_m1[2] <= c2[35] ? 36'(-c2) : 36'(c2);
            r_neg1  <= {c2[35], c1[35], c0[35]};
        end
    end

    // ---------------- stage 2: common shift to [2^30, 2^31) ----------------
    logic [35:0] mx1;
    logic [5:0] lp;
    always_comb begin
        mx1 = r_m1[0];
        if (r_m1[1] > mx1) mx1 = r_m1[1];
        if (r_m1[2] > mx1) mx1 = r_m1[2];
        lp = lead_one(mx1);
    end

    logic [30:0] r_m2 [3];
    logic [2:0] r_neg2;
    logic r_deg2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (lp >= 6'd30) begin
                    r_m2[i] <= 31'(r_m1[i] >> (lp - 6'd30));
                end else begin
                    r_m2[i] <= 31'(r_m1[i] << (6'd30 - lp));
                end
            end
            r_neg2 <= r_neg1;
            r_deg2 <= (mx1 == '0);
        end
    end

    // ---------------- stage 3: sum of squares, then root one bit per stage ----------------
    logic [61:0] sq [3];
    logic [63:0] r_rem [NSQ+1];
    logic [31:0] r_rt  [NSQ+1];
    logic [30:0] r_mq  [NSQ+1][3];
    logic [2:0]  r_ngq [NSQ+1];
    logic        r_dgq [NSQ+1];
    logic [31:0] cand  [NSQ];
    logic [63:0] trial [NSQ];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq[i] = r_m2[i] * r_m2[i];
        end
        for (int k = 0; k < NSQ; k++) begin
            cand[k]  = r_rt[k] | (32'd1 << (NSQ - 1 - k));
            trial[k] = cand[k] * cand[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
            r_rt[0]  <= '0;
            r_mq[0]  <= r_m2;
            r_ngq[0] <= r_neg2;
            r_dgq[0] <= r_deg2;
            for (int k = 0; k < NSQ; k++) begin
                r_rt[k+1]  <= (trial[k] <= r_rem[k]) ? cand[k] : r_rt[k];
                r_rem[k+1] <= r_rem[k];
                r_mq[k+1]  <= r_mq[k];
                r_ngq[k+1] <= r_ngq[k];
                r_dgq[k+1] <= r_dgq[k];
            end
        end
    end

    // ---------------- quotient, one bit per stage ----------------
    // u = floor((m*2^15 + n) / (2n)); at most 16 quotient bits before saturation
    logic [47:0] num_in [NDIV][3];
    logic [15:0] q_in   [NDIV][3];
    logic [32:0] dv_in  [NDIV];
    logic [2:0]  ng_in  [NDIV];
    logic        dg_in  [NDIV];
    logic [48:0] sub    [NDIV];
    logic [47:0] r_num  [NDIV][3];
    logic [15:0] r_q    [NDIV][3];
    logic [32:0] r_dv   [NDIV];
    logic [2:0]  r_ngd  [NDIV];
    logic        r_dgd  [NDIV];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_in[0][i] = (48'(r_mq[NSQ][i]) << 15) + 48'(r_rt[NSQ]);
            q_in[0][i]   = '0;
        end
        dv_in[0] = {r_rt[NSQ], 1'b0};
        ng_in[0] = r_ngq[NSQ];
        dg_in[0] = r_dgq[NSQ];
        for (int k = 1; k < NDIV; k++) begin
            num_in[k] = r_num[k-1];
            q_in[k]   = r_q[k-1];
            dv_in[k]  = r_dv[k-1];
            ng_in[k]  = r_ngd[k-1];
            dg_in[k]  = r_dgd[k-1];
        end
        for (int k = 0; k < NDIV; k++) begin
            sub[k] = 49'(dv_in[k]) << (NDIV - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NDIV; k++) begin
                for (int i = 0; i < 3; i++) begin
                    if (49'(num_in[k][i]) >= sub[k]) begin
                        r_num[k][i] <= 48'(49'(num_in[k][i]) - sub[k]);
                        r_q[k][i]   <= q_in[k][i] | (16'd1 << (NDIV - 1 - k));
                    end else begin
                        r_num[k][i] <= num_in[k][i];
                        r_q[k][i]   <= q_in[k][i];
                    end
                end
                r_dv[k]  <= dv_in[k];
                r_ngd[k] <= ng_in[k];
                r_dgd[k] <= dg_in[k];
            end
        end
    end

    // ---------------- output: saturate, sign, fallback ----------------
    logic [15:0] uo [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            uo[i] = (r_q[NDIV-1][i] > OUT_ONE) ? OUT_ONE : r_q[NDIV-1][i];
            if (r_ngd[NDIV-1][i]) begin
                uo[i] = 16'(-uo[i]);
            end
        end
        if (r_dgd[NDIV-1]) begin
            m_tdata = {OUT_ONE, 16'd0, 16'd0};
        end else begin
            m_tdata = {uo[2], uo[1], uo[0]};
        end
        m_tuser = r_dgd[NDIV-1];
    end

    `GNQ_ASSERT_IMP(a_deg_out, i_clk, i_rst_n, m_tvalid && m_tuser,
        m_tdata == (48'(OUT_ONE) << 32), "degenerate result is not (0,0,1)")
    `GNQ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")
    `GNQ_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, s_fire, r_vld[0],
        "accepted transfer did not enter the pipeline")

endmodule

// ===== test/tb_gaussian_normal_from_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// tb_gaussian_normal_from_quaternion_core
// streams gaussians with supplied normals or quaternions and scales through
// the normal core, predicts each unit normal and compares every transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gaussian_normal_from_quaternion_core;

    import gnq_pkg::*;

    localparam int CW = 16;
    localparam int N_RANDOM = 1530;

    typedef struct packed {
        logic               use_given;
        logic signed [15:0] gnx, gny, gnz;
        logic signed [15:0] qw, qx, qy, qz;
        logic signed [15:0] lsx, lsy, lsz;
    } t_gaussian;

    typedef struct packed {
        logic [15:0] nx, ny, nz;
        logic        degen;
    } t_normal;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [159:0] s_tdata;   // gnx, gny, gnz, qw, qx, qy, qz, lsx, lsy, lsz
    logic        s_tuser;    // use_given
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // nx, ny, nz
    logic        m_tuser;    // degenerate

    t_gaussian pending_items[$];
    t_normal   expected_normals[$];
    int        errors = 0;
    bit        rx_hold = 1'b0;
    bit        tx_quiet = 1'b0;
    bit        no_idle = 1'b0;
    int        hold_left;
    bit        hold_done;

    gaussian_normal_from_quaternion_core #(.COMPONENT_WIDTH(CW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] op);
        logic [63:0] res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > op) one = one >> 2;
        while (one != 0) begin
            if (op >= res + one) begin
                op = op - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic t_normal unit_normal(input t_gaussian g);
        t_normal r;
        longint v[3];
        longint w, x, y, z;
        logic [63:0] mag[3], mx, s, n, u;
        bit neg[3];
        t_axis ax;
        if (g.use_given) begin
            v[0] = g.gnx; v[1] = g.gny; v[2] = g.gnz;
        end else begin
            w = g.qw; x = g.qx; y = g.qy; z = g.qz;
            ax = AXIS_X;
            if (g.lsy < g.lsx) ax = AXIS_Y;
            if (((ax == AXIS_X) ? g.lsx : g.lsy) > g.lsz) ax = AXIS_Z;
            case (ax)
                AXIS_X: begin
                    v[0] = Q24_ONE - 2 * (y * y + z * z);
                    v[1] = 2 * (x * y + w * z);
                    v[2] = 2 * (x * z - w * y);
                end
                AXIS_Y: begin
                    v[0] = 2 * (x * y - w * z);
                    v[1] = Q24_ONE - 2 * (x * x + z * z);
                    v[2] = 2 * (y * z + w * x);
                end
                default: begin
                    v[0] = 2 * (x * z + w * y);
                    v[1] = 2 * (y * z - w * x);
                    v[2] = Q24_ONE - 2 * (x * x + y * y);
                end
            endcase
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            r.nx = 0; r.ny = 0; r.nz = OUT_ONE; r.degen = 1'b1;
            return r;
        end
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            mx = mx << 1;
        end
        s = 0;
        for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
        n = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            u = ((mag[i] << 15) + n) / (2 * n);
            if (u > OUT_ONE) u = OUT_ONE;
            mag[i] = neg[i] ? -u : u;
        end
        r.nx = mag[0][15:0]; r.ny = mag[1][15:0]; r.nz = mag[2][15:0];
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] rnd_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_gaussian rnd_gaussian();
        t_gaussian g;
        g.use_given = $urandom_range(0, 2) == 0;
        g.gnx = rnd_comp(); g.gny = rnd_comp(); g.gnz = rnd_comp();
        if ($urandom_range(0, 30) == 0) begin
            g.gnx = 0; g.gny = 0; g.gnz = 0;
        end
        g.qw = rnd_comp(); g.qx = rnd_comp(); g.qy = rnd_comp(); g.qz = rnd_comp();
        g.lsx = 16'($urandom); g.lsy = 16'($urandom); g.lsz = 16'($urandom);
        // ties in the scales
        if ($urandom_range(0, 7) == 0) g.lsy = g.lsx;
        if ($urandom_range(0, 7) == 0) g.lsz = $urandom_range(0, 1) ? g.lsx : g.lsy;
        return g;
    endfunction

    function automatic t_gaussian mk(input int hn, input int nx, ny, nz,
                                     input int w, x, y, z,
                                     input int sx, sy, sz);
        t_gaussian g;
        g.use_given = (hn != 0);
        g.gnx = 16'(nx); g.gny = 16'(ny); g.gnz = 16'(nz);
        g.qw = 16'(w); g.qx = 16'(x); g.qy = 16'(y); g.qz = 16'(z);
        g.lsx = 16'(sx); g.lsy = 16'(sy); g.lsz = 16'(sz);
        return g;
    endfunction

    task automatic add_item(input t_gaussian g);
        pending_items.insert(pending_items.size(), g);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_gaussian g;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() > 0 && !tx_quiet &&
                (no_idle || $urandom_range(0, 99) >= 6)) begin
                g = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= g.use_given;
                s_tdata <= {g.lsz, g.lsy, g.lsx, g.qz, g.qy, g.qx, g.qw,
                            g.gnz, g.gny, g.gnx};
                expected_normals.insert(expected_normals.size(), unit_normal(g));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver readiness, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (rx_hold && !hold_done) begin
            hold_left <= 300;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 6);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_normals.size() == 0) begin
                $display("%0t: unexpected transfer %h %b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                e = expected_normals.pop_front();
                if (m_tdata !== {e.nz, e.ny, e.nx} || m_tuser !== e.degen) begin
                    $display("%0t: expected %h %b actual %h %b", $time,
                             {e.nz, e.ny, e.nx}, e.degen, m_tdata, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("tb_gaussian_normal_from_quaternion_core failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        // directed cases
        add_item(mk(1, 0, 0, 0, 1, 2, 3, 4, 0, 0, 0));
        add_item(mk(1, 16'h7fff, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(1, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(1, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(1, 16'hffff, 1, 16'hffff, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(0, 0, 0, 0, 16'h1000, 0, 0, 0, 0, 0, 0));
        add_item(mk(0, 0, 0, 0, 16'h1000, 0, 0, 0, 5, 5, 6));
        add_item(mk(0, 0, 0, 0, 16'h1000, 0, 0, 0, 5, 4, 4));
        add_item(mk(0, 0, 0, 0, 16'h1000, 0, 0, 0, 5, 6, 4));
        add_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 16'h8000, 16'h7fff, 0));
        add_item(mk(0, 0, 0, 0, 0, 16'h0b50, 16'h0b50, 0, 0, 1, 1));
        add_item(mk(0, 0, 0, 0, 0, 16'h0800, 16'h0800, 0, 2, 2, 2));
        add_item(mk(0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h7fff, 16'h8000, 16'h7fff));
        add_item(mk(0, 0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'h7fff, 16'h7fff, 16'h8000));
        add_item(mk(0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                    16'h8000, 16'h7fff, 0, 0, 0));
        add_item(mk(0, 0, 0, 0, 0, 16'h0b50, 0, 16'h0b50, 1, 0, 1));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        // sender waits for the pipeline to drain
        tx_quiet = 1;
        wait (expected_normals.size() == 0);
        tx_quiet = 0;
        // long receiver hold-off while items keep coming
        for (int i = 0; i < 200; i++) add_item(rnd_gaussian());
        @(posedge i_clk);
        rx_hold = 1;
        wait (pending_items.size() == 0);
        tx_quiet = 1;
        wait (expected_normals.size() == 0);
        tx_quiet = 0;
        // stretch with no idling
        no_idle = 1;
        for (int i = 0; i < 200; i++) add_item(rnd_gaussian());
        wait (pending_items.size() == 0);
        wait (expected_normals.size() == 0);
        no_idle = 0;
        for (int i = 0; i < N_RANDOM - 400; i++) add_item(rnd_gaussian());
        wait (pending_items.size() == 0);
        wait (expected_normals.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("tb_gaussian_normal_from_quaternion_core passed");
        end else begin
            $display("tb_gaussian_normal_from_quaternion_core failed");
        end
        $finish;
    end

endmodule

// ===== gaussian_normal_from_quaternion_core.f =====
+incdir+src
src/gnq_pkg.sv
src/gaussian_normal_from_quaternion_core.sv
test/tb_gaussian_normal_from_quaternion_core.sv
